[rtl/min_sum_of_segment_max_partition_macros.svh]
// Assertion macros for the partition search top-level RTL
`ifndef MIN_SUM_OF_SEGMENT_MAX_PARTITION_MACROS_SVH
`define MIN_SUM_OF_SEGMENT_MAX_PARTITION_MACROS_SVH

// Check a condition at every clock edge outside reset
`define MSMP_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition on the next edge
`define MSMP_ASSERT_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[rtl/msmp_pkg.sv]
// Shared types and constants for the partition search block
package msmp_pkg;

    localparam int SUM_W         = 14;
    localparam int DIFF_W        = 10;
    localparam int DAYS_W        = 5;
    localparam int MAX_JOBS_DEF  = 512;
    localparam int MAX_DAYS_DEF  = 16;

    typedef struct packed {
        logic              vld;
        logic [SUM_W-1:0]  val;
    } fval_t;

    typedef struct packed {
        logic clear;
        logic accum;
        logic t_zero;
        logic wr_en;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SWEEP,
        ST_DRAIN,
        ST_WRITE,
        ST_RES_RD,
        ST_RES_CAP,
        ST_DONE
    } state_t;

endpackage

[rtl/msmp_if.sv]
// Valid/ready channel interfaces for jobs and results
interface msmp_job_if import msmp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIFF_W-1:0] difficulty;
    logic              last_job;

    modport source (output valid, output difficulty, output last_job, input ready);
    modport sink   (input valid, input difficulty, input last_job, output ready);
endinterface

interface msmp_result_if import msmp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] min_total;
    logic             impossible;

    modport source (output valid, output min_total, output impossible, input ready);
    modport sink   (input valid, input min_total, input impossible, output ready);
endinterface

[rtl/msmp_ram.sv]
// Generic single-write, single-read RAM with registered read data
module msmp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/msmp_cell.sv]
// One day of the table: holds its row in RAM and folds candidates from the previous day
module msmp_cell import msmp_pkg::*; #(
    parameter int MAX_JOBS = MAX_JOBS_DEF,
    parameter bit FIRST    = 1'b0,
    parameter int AW       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  logic [AW-1:0]     raddr,
    input  logic [AW-1:0]     waddr,
    input  logic [DIFF_W-1:0] run_max,
    input  fval_t             prev_rd,
    output fval_t             rd
);

    fval_t prev_eff;
    fval_t cand;
    fval_t best_reg;
    fval_t best_next;
    logic [$bits(fval_t)-1:0] ram_rd;

    // An empty prefix is reachable with zero days only
    always_comb
    begin
        if (ctl.t_zero)
        begin
            prev_eff.vld = FIRST;
            prev_eff.val = '0;
        end
        else if (FIRST)
        begin
            prev_eff.vld = 1'b0;
            prev_eff.val = '0;
        end
        else
        begin
            prev_eff = prev_rd;
        end
        cand.vld = prev_eff.vld;
        cand.val = prev_eff.val + SUM_W'(run_max);
    end

    always_comb
    begin
        best_next = best_reg;
        if (ctl.clear)
        begin
            best_next.vld = 1'b0;
        end
        else if (ctl.accum && cand.vld && (!best_reg.vld || cand.val < best_reg.val))
        begin
            best_next = cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    msmp_ram #(
        .WIDTH ($bits(fval_t)),
        .DEPTH (MAX_JOBS)
    ) u_row (
        .clk   (clk),
        .we    (ctl.wr_en),
        .waddr (waddr),
        .wdata (best_reg),
        .raddr (raddr),
        .rdata (ram_rd)
    );

    assign rd = fval_t'(ram_rd);

endmodule

[rtl/min_sum_of_segment_max_partition.sv]
// Least sum of segment maxima over a loaded job sequence, one cell per day count.
// Loading: one job per cycle, ready whenever the sequencer is in its load state.
// Compute: for each prefix length j = 1..n a sweep of j reads of the job RAM, then a drain and
// a write state; after the last prefix the result is read from the cell RAM and captured.
// Impossible cases skip the sweep and go straight to the done state. One sequence at a time.
// Reset (async, active low) clears the sequencer, job count and output valid; num_days resets to 1.
module min_sum_of_segment_max_partition import msmp_pkg::*; #(
    parameter int MAX_JOBS = MAX_JOBS_DEF,
    parameter int MAX_DAYS = MAX_DAYS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    msmp_job_if.sink          job,
    msmp_result_if.source     result,
    input  logic              cfg_wr_en,
    input  logic [DAYS_W-1:0] cfg_wr_data
);

    `include "min_sum_of_segment_max_partition_macros.svh"

    localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int DW = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [AW-1:0]     t_reg, t_next;
    logic [DIFF_W-1:0] m_reg, m_next;
    logic              dvld_reg, dvld_next;
    logic              tz_reg, tz_next;
    logic [DAYS_W-1:0] num_days_reg;
    logic [SUM_W-1:0]  res_total_reg, res_total_next;
    logic              res_imp_reg, res_imp_next;
    logic              out_vld_reg, out_vld_next;
    logic [SUM_W-1:0]  out_total_reg;
    logic              out_imp_reg;

    logic              accept;
    logic              store_ok;
    logic [CW-1:0]     n_new;
    logic              no_split;
    logic [DIFF_W-1:0] job_rd;
    logic [DIFF_W-1:0] m_cur;
    logic [AW-1:0]     cell_raddr;
    logic [AW-1:0]     cell_waddr;
    logic [DW-1:0]     sel;
    cell_ctl_t         ctl;
    fval_t             cell_rd [MAX_DAYS];

    assign accept   = job.valid && job.ready;
    assign store_ok = (count_reg < CW'(MAX_JOBS));
    assign n_new    = store_ok ? count_reg + CW'(1) : count_reg;
    assign no_split = (num_days_reg == '0) || (32'(num_days_reg) > MAX_DAYS)
                      || (CW'(num_days_reg) > n_new);
    assign m_cur    = (job_rd > m_reg) ? job_rd : m_reg;
    assign sel      = DW'(num_days_reg - DAYS_W'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept && job.last_job)
                begin
                    state_next = no_split ? ST_DONE : ST_SWEEP;
                end
            end
            ST_SWEEP:   state_next = (t_reg == '0) ? ST_DRAIN : ST_SWEEP;
            ST_DRAIN:   state_next = ST_WRITE;
            ST_WRITE:   state_next = (j_reg == n_reg) ? ST_RES_RD : ST_SWEEP;
            ST_RES_RD:  state_next = ST_RES_CAP;
            ST_RES_CAP: state_next = ST_DONE;
            ST_DONE:    state_next = out_vld_reg ? ST_DONE : ST_LOAD;
            default:    state_next = ST_LOAD;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        job.ready  = (state_reg == ST_LOAD);
        ctl.clear  = (state_reg == ST_LOAD) || (state_reg == ST_WRITE);
        ctl.accum  = dvld_reg;
        ctl.t_zero = tz_reg;
        ctl.wr_en  = (state_reg == ST_WRITE);
        dvld_next  = (state_reg == ST_SWEEP);
        tz_next    = (t_reg == '0);
        cell_raddr = (state_reg == ST_RES_RD) ? AW'(n_reg - CW'(1)) : t_reg - AW'(1);
        cell_waddr = AW'(j_reg - CW'(1));
    end

    // Counters and result
    always_comb
    begin
        count_next     = count_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        t_next         = t_reg;
        m_next         = m_reg;
        res_total_next = res_total_reg;
        res_imp_next   = res_imp_reg;
        out_vld_next   = out_vld_reg;

        if (result.valid && result.ready)
        begin
            out_vld_next = 1'b0;
        end

        if (ctl.clear)
        begin
            m_next = '0;
        end
        else if (dvld_reg)
        begin
            m_next = m_cur;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    count_next = n_new;
                    if (job.last_job)
                    begin
                        count_next     = '0;
                        n_next         = n_new;
                        j_next         = CW'(1);
                        t_next         = '0;
                        res_total_next = '0;
                        res_imp_next   = no_split;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (t_reg != '0)
                begin
                    t_next = t_reg - AW'(1);
                end
            end
            ST_WRITE:
            begin
                // Next prefix starts its sweep at its last job
                j_next = j_reg + CW'(1);
                t_next = AW'(j_reg);
            end
            ST_RES_CAP:
            begin
                res_total_next = cell_rd[sel].val;
                res_imp_next   = 1'b0;
            end
            ST_DONE:
            begin
                if (!out_vld_reg)
                begin
                    out_vld_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            n_reg        <= '0;
            j_reg        <= '0;
            t_reg        <= '0;
            dvld_reg     <= 1'b0;
            tz_reg       <= 1'b0;
            num_days_reg <= DAYS_W'(1);
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            n_reg       <= n_next;
            j_reg       <= j_next;
            t_reg       <= t_next;
            dvld_reg    <= dvld_next;
            tz_reg      <= tz_next;
            out_vld_reg <= out_vld_next;
            if (cfg_wr_en)
            begin
                num_days_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg         <= m_next;
        res_total_reg <= res_total_next;
        res_imp_reg   <= res_imp_next;
        if (state_reg == ST_DONE && !out_vld_reg)
        begin
            out_total_reg <= res_total_reg;
            out_imp_reg   <= res_imp_reg;
        end
    end

    assign result.valid      = out_vld_reg;
    assign result.min_total  = out_total_reg;
    assign result.impossible = out_imp_reg;

    msmp_ram #(
        .WIDTH (DIFF_W),
        .DEPTH (MAX_JOBS)
    ) u_jobs (
        .clk   (clk),
        .we    (accept && store_ok),
        .waddr (count_reg[AW-1:0]),
        .wdata (job.difficulty),
        .raddr (t_reg),
        .rdata (job_rd)
    );

    for (genvar g = 0; g < MAX_DAYS; g++)
    begin : g_cell
        msmp_cell #(
            .MAX_JOBS (MAX_JOBS),
            .FIRST    (g == 0)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .raddr   (cell_raddr),
            .waddr   (cell_waddr),
            .run_max (m_cur),
            .prev_rd (cell_rd[(g == 0) ? 0 : g - 1]),
            .rd      (cell_rd[g])
        );
    end

    `MSMP_ASSERT(a_count_bound, count_reg <= CW'(MAX_JOBS), "job count past store depth")
    `MSMP_ASSERT(a_sweep_bound, (state_reg != ST_SWEEP) || (CW'(t_reg) < j_reg), "bad sweep")
    `MSMP_ASSERT_NEXT(a_result_load, state_reg == ST_DONE && !out_vld_reg, out_vld_reg, "result not loaded")

endmodule

[dv/min_sum_of_segment_max_partition_checker.sv]
// Checker: watches the job, result and config ports, predicts each result and compares
module min_sum_of_segment_max_partition_checker import msmp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    msmp_job_if               job,
    msmp_result_if            result,
    input  logic              cfg_wr_en,
    input  logic [DAYS_W-1:0] cfg_wr_data,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [SUM_W-1:0] min_total;
        logic             impossible;
    } partition_result_t;

    logic [DIFF_W-1:0]  job_list[$];
    logic [DAYS_W-1:0]  days_setting;
    partition_result_t  expected_results[$];

    // Least sum of segment maxima over the jobs, split into exactly `days` segments
    function automatic partition_result_t best_partition(logic [DIFF_W-1:0] jobs[$],
                                                         int unsigned days);
        partition_result_t r;
        int unsigned n;
        int unsigned tail_best[];
        int unsigned next_best[];
        int unsigned run;
        int unsigned best;
        int unsigned cand;
        n = jobs.size();
        r.min_total  = '0;
        r.impossible = 1'b1;
        if (days == 0 || days > MAX_DAYS_DEF || days > n || n == 0)
            return r;
        tail_best = new[n];
        next_best = new[n];
        run = 0;
        for (int i = n - 1; i >= 0; i--)
        begin
            if (jobs[i] > run)
                run = jobs[i];
            tail_best[i] = run;
        end
        for (int k = 2; k <= days; k++)
        begin
            for (int i = 0; i <= n - k; i++)
            begin
                best = 32'hFFFF_FFFF;
                run = 0;
                for (int j = i; j <= n - k; j++)
                begin
                    if (jobs[j] > run)
                        run = jobs[j];
                    cand = run + tail_best[j + 1];
                    if (cand < best)
                        best = cand;
                end
                next_best[i] = best;
            end
            for (int i = 0; i <= n - k; i++)
                tail_best[i] = next_best[i];
        end
        r.min_total  = tail_best[0][SUM_W-1:0];
        r.impossible = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        partition_result_t e;
        if (!rst_n)
        begin
            job_list.delete();
            expected_results.delete();
            days_setting <= 5'd1;
            fail_count   <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                days_setting <= cfg_wr_data;
            if (job.valid && job.ready)
            begin
                // drop jobs once the store is full
                if (job_list.size() < MAX_JOBS_DEF)
                    job_list.push_back(job.difficulty);
                if (job.last_job)
                begin
                    expected_results.push_back(best_partition(job_list, days_setting));
                    job_list.delete();
                end
            end
            if (result.valid && result.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result min_total=%0d impossible=%0b",
                                 result.min_total, result.impossible);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (result.min_total !== e.min_total || result.impossible !== e.impossible)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: min_total exp %0d got %0d, impossible exp %0b got %0b",
                                     e.min_total, result.min_total, e.impossible,
                                     result.impossible);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending <= expected_results.size();
    end
endmodule

[dv/min_sum_of_segment_max_partition_test.sv]
// Testbench top: drives job sequences and day settings, gives the verdict
module min_sum_of_segment_max_partition_test;
    import msmp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [DAYS_W-1:0] cfg_wr_data;
    int                fail_count;
    int                pending;
    bit                no_idle;

    msmp_job_if    job();
    msmp_result_if result();

    min_sum_of_segment_max_partition u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (job.sink),
        .result      (result.source),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    min_sum_of_segment_max_partition_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (job),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #30ms;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random stall before each transaction
    initial
    begin
        int stall;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            do @(posedge clk); while (!result.valid);
        end
    end

    task automatic send_job(input logic [DIFF_W-1:0] diff, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            job.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        job.valid      <= 1'b1;
        job.difficulty <= diff;
        job.last_job   <= last;
        do @(posedge clk); while (!job.ready);
    endtask

    task automatic send_sequence(input int len);
        for (int i = 0; i < len; i++)
            send_job(10'($urandom()), i == len - 1);
    endtask

    // Hold until the block is idle, then write the day count
    task automatic set_days(input logic [DAYS_W-1:0] days);
        job.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= days;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int sent;
        int len;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        job.valid      = 1'b0;
        job.difficulty = '0;
        job.last_job   = 1'b0;
        no_idle        = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-job extremes and a three-job sequence with the reset day count
        send_job(10'd0, 1'b1);
        send_job(10'd1023, 1'b1);
        send_job(10'd1023, 1'b0);
        send_job(10'd0, 1'b0);
        send_job(10'd512, 1'b1);
        set_days(5'd16);
        send_sequence(16);
        send_sequence(15);
        set_days(5'd0);
        send_sequence(3);
        set_days(5'd31);
        send_sequence(20);
        set_days(5'd17);
        send_sequence(18);
        set_days(5'd2);
        send_job(10'd1023, 1'b0);
        send_job(10'd1023, 1'b1);
        send_job(10'd7, 1'b1);
        // overfill the store; the marked job still starts the search
        set_days(5'd16);
        send_sequence(520);

        sent = 0;
        while (sent < 500)
        begin
            if ($urandom_range(0, 7) == 0)
                set_days(5'($urandom()));
            else
                set_days(5'($urandom_range(1, 16)));
            repeat ($urandom_range(3, 6))
            begin
                no_idle = ($urandom_range(0, 3) == 0);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 20);
                send_sequence(len);
                sent += len;
            end
        end
        job.valid <= 1'b0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
